>>> hw/rtl/mcfp_pkg.sv
// Package for the mouse command frame parser: parser state encoding,
// protocol byte codes and the result bundle passed from parser to output stage.
// No dependencies.
package mcfp_pkg;

    localparam logic [7:0] SYNC_BYTE     = 8'hAA;
    localparam logic [7:0] WAIT_CMD_BYTE = 8'hFF;

    localparam logic [7:0] CMD_STOP    = 8'h00;
    localparam logic [7:0] CMD_ABS     = 8'h01;
    localparam logic [7:0] CMD_REL     = 8'h02;
    localparam logic [7:0] CMD_ABS_BTN = 8'h03;

    // Coordinate payload bytes of an absolute command
    localparam logic [2:0] COORD_BYTES = 3'd4;
    localparam logic [2:0] COORD_LAST  = 3'd3;

    localparam logic REPORT_ABS = 1'b0;
    localparam logic REPORT_REL = 1'b1;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_CMD     = 6'b000010,
        PH_ABS     = 6'b000100,
        PH_ABS_BTN = 6'b001000,
        PH_REL     = 6'b010000,
        PH_SKIP    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic        valid;
        logic        report_kind;
        logic [15:0] abs_x;
        logic [15:0] abs_y;
        logic        abs_button;
        logic [7:0]  rel_buttons;
    } report_t;

endpackage

>>> hw/rtl/mcfp_parser.sv
// Frame parser core: phase register, coordinate/button storage and the
// per-byte decode that produces at most one report per beat. Uses mcfp_pkg.
module mcfp_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              beat,
    input  logic [7:0]        rx_byte,
    output mcfp_pkg::report_t report
);

    mcfp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]       index_reg, index_next;
    logic [15:0]      pos_x_reg, pos_x_next;
    logic [15:0]      pos_y_reg, pos_y_next;
    logic             button_reg, button_next;
    mcfp_pkg::report_t rep;

    always_comb begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        button_next = button_reg;
        rep         = '0;

        unique case (phase_reg)
            mcfp_pkg::PH_IDLE: begin
                if (rx_byte == mcfp_pkg::SYNC_BYTE) begin
                    phase_next = mcfp_pkg::PH_CMD;
                end
            end
            mcfp_pkg::PH_CMD: begin
                index_next = '0;
                unique case (rx_byte)
                    mcfp_pkg::CMD_STOP:      phase_next = mcfp_pkg::PH_IDLE;
                    mcfp_pkg::CMD_ABS:       phase_next = mcfp_pkg::PH_ABS;
                    mcfp_pkg::CMD_REL:       phase_next = mcfp_pkg::PH_REL;
                    mcfp_pkg::CMD_ABS_BTN:   phase_next = mcfp_pkg::PH_ABS_BTN;
                    mcfp_pkg::WAIT_CMD_BYTE: phase_next = mcfp_pkg::PH_CMD;
                    default:                 phase_next = mcfp_pkg::PH_SKIP;
                endcase
            end
            mcfp_pkg::PH_ABS, mcfp_pkg::PH_ABS_BTN: begin
                if (index_reg < mcfp_pkg::COORD_BYTES) begin
                    unique case (index_reg[1:0])
                        2'd0: pos_x_next = {pos_x_reg[15:8], rx_byte};
                        2'd1: pos_x_next = {rx_byte, pos_x_reg[7:0]};
                        2'd2: pos_y_next = {pos_y_reg[15:8], rx_byte};
                        default: pos_y_next = {rx_byte, pos_y_reg[7:0]};
                    endcase
                    index_next = index_reg + 3'd1;
                    if (index_reg == mcfp_pkg::COORD_LAST &&
                        phase_reg == mcfp_pkg::PH_ABS) begin
                        phase_next = mcfp_pkg::PH_IDLE;
                        index_next = '0;
                        rep.valid  = 1'b1;
                    end
                end else begin
                    // Button byte of command 3
                    button_next = (rx_byte != 8'd0);
                    phase_next  = mcfp_pkg::PH_IDLE;
                    index_next  = '0;
                    rep.valid   = 1'b1;
                end
                rep.report_kind = mcfp_pkg::REPORT_ABS;
                rep.abs_x       = pos_x_next;
                rep.abs_y       = pos_y_next;
                rep.abs_button  = button_next;
            end
            mcfp_pkg::PH_REL: begin
                phase_next      = mcfp_pkg::PH_IDLE;
                index_next      = '0;
                rep.valid       = 1'b1;
                rep.report_kind = mcfp_pkg::REPORT_REL;
                rep.rel_buttons = rx_byte;
            end
            default: begin
                // Discard phase and unreachable codes: drop the byte
                phase_next = mcfp_pkg::PH_IDLE;
                index_next = '0;
            end
        endcase

        if (!rep.valid) begin
            rep = '0;
        end
        rep.valid = rep.valid & beat;
    end

    assign report = rep;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= mcfp_pkg::PH_IDLE;
            index_reg  <= '0;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            button_reg <= 1'b0;
        end else if (beat) begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            button_reg <= button_next;
        end
    end

endmodule

>>> hw/rtl/mouse_command_frame_parser_top.sv
// A report appears on m_* in the cycle after the beat that ends its frame.
// Throughput: one byte per cycle; the only limit is the single output register,
// which takes a new report in the same cycle the held one is taken.
// Reset: synchronous, active-low aresetn returns the parser to sync hunting,
// clears the stored X, Y and button, and empties the output register.
// Top level of the mouse command frame parser; uses mcfp_pkg and mcfp_parser.
module mouse_command_frame_parser_top (
    input  logic        aclk,
    input  logic        aresetn,

    // Received serial bytes, one per beat
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,

    // Report channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_report_kind,
    output logic [15:0] m_abs_x,
    output logic [15:0] m_abs_y,
    output logic        m_abs_button,
    output logic [7:0]  m_rel_buttons
);

    logic              in_beat;
    mcfp_pkg::report_t report;

    logic        m_valid_reg, m_valid_next;
    logic        kind_reg;
    logic [15:0] abs_x_reg;
    logic [15:0] abs_y_reg;
    logic        abs_button_reg;
    logic [7:0]  rel_buttons_reg;

    // Accept a byte whenever the output register is empty or being drained
    // this cycle; a byte that makes no report never needs the output side,
    // but keeping one rule keeps the ready path to a single gate.
    assign s_ready = !m_valid_reg || m_ready;
    assign in_beat = s_valid && s_ready;

    // The parser does all per-byte work combinationally from the current
    // phase and the incoming byte; its state advances only on a beat.
    mcfp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .beat    (in_beat),
        .rx_byte (s_rx_byte),
        .report  (report)
    );

    // Output register: load a new report on the beat that finishes a frame,
    // otherwise drop the held report once the consumer takes it.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (report.valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload holds with no reset; it only matters while m_valid is high.
    always_ff @(posedge aclk) begin
        if (report.valid) begin
            kind_reg        <= report.report_kind;
            abs_x_reg       <= report.abs_x;
            abs_y_reg       <= report.abs_y;
            abs_button_reg  <= report.abs_button;
            rel_buttons_reg <= report.rel_buttons;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_report_kind = kind_reg;
    assign m_abs_x       = abs_x_reg;
    assign m_abs_y       = abs_y_reg;
    assign m_abs_button  = abs_button_reg;
    assign m_rel_buttons = rel_buttons_reg;

endmodule

>>> hw/rtl/mcfp_checker.sv
// Port-level checks for the mouse command frame parser top level, plus the
// bind that attaches them. Depends on mouse_command_frame_parser_top.
module mcfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_report_kind,
    input logic [15:0] m_abs_x,
    input logic [15:0] m_abs_y,
    input logic        m_abs_button,
    input logic [7:0]  m_rel_buttons
);

    // A stalled report holds its beat unchanged
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_report_kind) &&
        $stable(m_abs_x) && $stable(m_abs_y) && $stable(m_abs_button) &&
        $stable(m_rel_buttons))
        else $error("stalled report changed");

    // No byte may be taken while a report is stuck in the output register
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && s_valid |-> !s_ready)
        else $error("input accepted over a stalled report");

    a_rel_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_report_kind |->
        m_abs_x == 16'd0 && m_abs_y == 16'd0 && m_abs_button == 1'b0)
        else $error("relative report carries absolute fields");

    a_abs_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_report_kind |-> m_rel_buttons == 8'd0)
        else $error("absolute report carries button mask");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("report present after reset");

endmodule

bind mouse_command_frame_parser_top mcfp_checker u_mcfp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_report_kind (m_report_kind),
    .m_abs_x       (m_abs_x),
    .m_abs_y       (m_abs_y),
    .m_abs_button  (m_abs_button),
    .m_rel_buttons (m_rel_buttons)
);

>>> tb/mcfp_report_checker.sv
// Scoreboard for the mouse command frame parser: watches the byte and report channels,
// tracks the frame state from accepted bytes and compares every report taken.
// Depends on mcfp_pkg for the phase encoding, protocol codes and report bundle.
`timescale 1ns / 1ps

module mcfp_report_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_report_kind,
    input  logic [15:0] m_abs_x,
    input  logic [15:0] m_abs_y,
    input  logic        m_abs_button,
    input  logic [7:0]  m_rel_buttons,
    output int          error_count,
    output int          pending_reports
);

    mcfp_pkg::phase_t parse_phase = mcfp_pkg::PH_IDLE;
    logic [2:0]  coord_count = '0;
    logic [15:0] pos_x = '0;
    logic [15:0] pos_y = '0;
    logic        button_bit = 1'b0;

    mcfp_pkg::report_t expected_reports[$];
    int          errors_seen = 0;

    task automatic report_error(input string msg);
        $display("%0t ns: report mismatch: %s", $time, msg);
        errors_seen++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_error($sformatf("%s got %0h, want %0h", name, got, want));
        end
    endtask

    task automatic queue_abs_report();
        mcfp_pkg::report_t r;
        r             = '0;
        r.valid       = 1'b1;
        r.report_kind = mcfp_pkg::REPORT_ABS;
        r.abs_x       = pos_x;
        r.abs_y       = pos_y;
        r.abs_button  = button_bit;
        expected_reports.push_back(r);
    endtask

    task automatic queue_rel_report(input logic [7:0] buttons);
        mcfp_pkg::report_t r;
        r             = '0;
        r.valid       = 1'b1;
        r.report_kind = mcfp_pkg::REPORT_REL;
        r.rel_buttons = buttons;
        expected_reports.push_back(r);
    endtask

    // Advance the frame state by one accepted byte; queue the report it completes.
    task automatic advance_frame_parser(input logic [7:0] rx);
        case (parse_phase)
            mcfp_pkg::PH_IDLE: begin
                if (rx == mcfp_pkg::SYNC_BYTE) parse_phase = mcfp_pkg::PH_CMD;
            end
            mcfp_pkg::PH_CMD: begin
                coord_count = '0;
                case (rx)
                    mcfp_pkg::CMD_STOP:      parse_phase = mcfp_pkg::PH_IDLE;
                    mcfp_pkg::CMD_ABS:       parse_phase = mcfp_pkg::PH_ABS;
                    mcfp_pkg::CMD_REL:       parse_phase = mcfp_pkg::PH_REL;
                    mcfp_pkg::CMD_ABS_BTN:   parse_phase = mcfp_pkg::PH_ABS_BTN;
                    mcfp_pkg::WAIT_CMD_BYTE: parse_phase = mcfp_pkg::PH_CMD;
                    default:                 parse_phase = mcfp_pkg::PH_SKIP;
                endcase
            end
            mcfp_pkg::PH_ABS, mcfp_pkg::PH_ABS_BTN: begin
                if (coord_count < mcfp_pkg::COORD_BYTES) begin
                    // little-endian: X low, X high, Y low, Y high
                    case (coord_count)
                        3'd0:    pos_x[7:0]  = rx;
                        3'd1:    pos_x[15:8] = rx;
                        3'd2:    pos_y[7:0]  = rx;
                        default: pos_y[15:8] = rx;
                    endcase
                    coord_count = coord_count + 3'd1;
                    if (coord_count == mcfp_pkg::COORD_BYTES &&
                        parse_phase == mcfp_pkg::PH_ABS) begin
                        parse_phase = mcfp_pkg::PH_IDLE;
                        coord_count = '0;
                        queue_abs_report();
                    end
                end else begin
                    button_bit  = (rx != 8'h00);
                    parse_phase = mcfp_pkg::PH_IDLE;
                    coord_count = '0;
                    queue_abs_report();
                end
            end
            mcfp_pkg::PH_REL: begin
                parse_phase = mcfp_pkg::PH_IDLE;
                coord_count = '0;
                queue_rel_report(rx);
            end
            default: begin
                // drop the byte after an unknown command
                parse_phase = mcfp_pkg::PH_IDLE;
                coord_count = '0;
            end
        endcase
    endtask

    task automatic check_report();
        mcfp_pkg::report_t want;
        if (expected_reports.size() == 0) begin
            report_error("report beat with nothing outstanding");
        end else begin
            want = expected_reports.pop_front();
            check_field("report_kind", m_report_kind, want.report_kind);
            check_field("abs_x", m_abs_x, want.abs_x);
            check_field("abs_y", m_abs_y, want.abs_y);
            check_field("abs_button", m_abs_button, want.abs_button);
            check_field("rel_buttons", m_rel_buttons, want.rel_buttons);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            parse_phase = mcfp_pkg::PH_IDLE;
            coord_count = '0;
            pos_x       = '0;
            pos_y       = '0;
            button_bit  = 1'b0;
            expected_reports.delete();
        end else begin
            // a report never leaves in the cycle its last byte arrives
            if (m_valid && m_ready) check_report();
            if (s_valid && s_ready) advance_frame_parser(s_rx_byte);
        end
        error_count     <= errors_seen;
        pending_reports <= expected_reports.size();
    end

endmodule

>>> tb/mouse_command_frame_parser_top_tb.sv
// Top of the mouse command frame parser testbench: clock, reset, byte stimulus,
// report back-pressure and the final verdict. Depends on mcfp_pkg,
// mouse_command_frame_parser_top and mcfp_report_checker.
`timescale 1ns / 1ps

module mouse_command_frame_parser_top_tb;

    // The cycle limit sits well above the worst case, even with both sides stalling.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_CYCLES = 8;

    // A command byte outside the known set: the block must drop the next byte.
    localparam logic [7:0] UNKNOWN_CMD = 8'h07;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_ready   = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_report_kind;
    logic [15:0] m_abs_x;
    logic [15:0] m_abs_y;
    logic        m_abs_button;
    logic [7:0]  m_rel_buttons;

    int error_count;
    int pending_reports;
    int cycle_count = 0;
    int items_sent  = 0;

    // Idle bursts on each side; cleared for quiet stretches and the closing part.
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;

    // Directed frames: the extremes of every field, each command, the wait byte,
    // the stop byte and a sync byte that gets swallowed after an unknown command.
    logic [7:0] directed_bytes [26] = '{
        8'h55,                                                  // noise while hunting sync
        mcfp_pkg::SYNC_BYTE, mcfp_pkg::CMD_ABS,
        8'hFF, 8'hFF, 8'hFF, 8'hFF,                             // max coordinates
        mcfp_pkg::SYNC_BYTE, mcfp_pkg::CMD_ABS_BTN,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
        mcfp_pkg::SYNC_BYTE, mcfp_pkg::CMD_REL, 8'hFF,
        mcfp_pkg::SYNC_BYTE, mcfp_pkg::WAIT_CMD_BYTE,           // wait byte, then relative
        mcfp_pkg::CMD_REL, 8'h00,
        mcfp_pkg::SYNC_BYTE, mcfp_pkg::CMD_STOP,
        mcfp_pkg::SYNC_BYTE, UNKNOWN_CMD, mcfp_pkg::SYNC_BYTE   // discarded sync
    };

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    mouse_command_frame_parser_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_report_kind (m_report_kind),
        .m_abs_x       (m_abs_x),
        .m_abs_y       (m_abs_y),
        .m_abs_button  (m_abs_button),
        .m_rel_buttons (m_rel_buttons)
    );

    mcfp_report_checker report_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_report_kind   (m_report_kind),
        .m_abs_x         (m_abs_x),
        .m_abs_y         (m_abs_y),
        .m_abs_button    (m_abs_button),
        .m_rel_buttons   (m_rel_buttons),
        .error_count     (error_count),
        .pending_reports (pending_reports)
    );

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("mouse_command_frame_parser_top_tb: done, errors");
            $finish;
        end
    end

    // Report side: hold ready high, drop it for a random burst now and then.
    initial begin
        @(posedge aclk);
        forever begin
            if (receiver_idles && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Biased byte: the extremes show up often, everything else uniformly.
    function automatic logic [7:0] pick_payload_byte();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 8'h00;
        if (sel == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Drive one beat: maybe idle first, then hold valid and the byte until taken.
    // Valid is left high afterwards so back-to-back beats need no second write.
    task automatic send_byte(input logic [7:0] rx, input bit counted);
        if (sender_idles && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (counted) items_sent++;
    endtask

    task automatic send_abs_frame(input bit with_button);
        send_byte(mcfp_pkg::SYNC_BYTE, 1'b1);
        send_byte(with_button ? mcfp_pkg::CMD_ABS_BTN : mcfp_pkg::CMD_ABS, 1'b1);
        repeat (mcfp_pkg::COORD_BYTES) send_byte(pick_payload_byte(), 1'b1);
        if (with_button) begin
            // At least half of the button bytes are zero so the bit clears at least as often as it sets.
            send_byte($urandom_range(0, 1) ? 8'h00 : pick_payload_byte(), 1'b1);
        end
    endtask

    task automatic send_random_frame();
        int pick;
        logic [7:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            send_abs_frame(1'b0);
        end else if (pick < 55) begin
            send_abs_frame(1'b1);
        end else if (pick < 72) begin
            send_byte(mcfp_pkg::SYNC_BYTE, 1'b1);
            send_byte(mcfp_pkg::CMD_REL, 1'b1);
            send_byte(pick_payload_byte(), 1'b1);
        end else if (pick < 77) begin
            send_byte(mcfp_pkg::SYNC_BYTE, 1'b1);
            send_byte(mcfp_pkg::CMD_STOP, 1'b1);
        end else if (pick < 83) begin
            // Hold the parser in the command phase before a real command.
            send_byte(mcfp_pkg::SYNC_BYTE, 1'b1);
            repeat ($urandom_range(1, 3)) send_byte(mcfp_pkg::WAIT_CMD_BYTE, 1'b1);
            if ($urandom_range(0, 1)) begin
                send_byte(mcfp_pkg::CMD_REL, 1'b1);
                send_byte(pick_payload_byte(), 1'b1);
            end else begin
                send_byte(mcfp_pkg::CMD_ABS, 1'b1);
                repeat (mcfp_pkg::COORD_BYTES) send_byte(pick_payload_byte(), 1'b1);
            end
        end else if (pick < 89) begin
            // Unknown command; the dropped byte is often a sync byte.
            cmd = 8'($urandom_range(mcfp_pkg::CMD_ABS_BTN + 1,
                                    mcfp_pkg::WAIT_CMD_BYTE - 1));
            send_byte(mcfp_pkg::SYNC_BYTE, 1'b1);
            send_byte(cmd, 1'b1);
            send_byte($urandom_range(0, 1) ? mcfp_pkg::SYNC_BYTE : pick_payload_byte(),
                      1'b1);
        end else if (pick < 95) begin
            // Line noise; ignored when the parser is hunting, so not counted.
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            // Truncated absolute frame: the next frame's bytes land in its payload.
            send_byte(mcfp_pkg::SYNC_BYTE, 1'b1);
            send_byte($urandom_range(0, 1) ? mcfp_pkg::CMD_ABS : mcfp_pkg::CMD_ABS_BTN,
                      1'b1);
            repeat ($urandom_range(0, 3)) send_byte(pick_payload_byte(), 1'b1);
        end
    endtask

    // Main stimulus: reset, directed frames, random frames, drain, verdict.
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_bytes[i]) send_byte(directed_bytes[i], 1'b1);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            // Quiet stretch in the middle, none at all in the closing part.
            if (items_sent > RANDOM_ITEMS - 150) begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
            end else if (items_sent > 300 && items_sent < 380) begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
            end else begin
                sender_idles   = 1'b1;
                receiver_idles = 1'b1;
            end
            send_random_frame();
        end
        s_valid <= 1'b0;

        // Let the checker's counters settle past the last accepted beat, then drain.
        @(posedge aclk);
        while (pending_reports != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("mouse_command_frame_parser_top_tb: done, clean");
        end else begin
            $display("mouse_command_frame_parser_top_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mcfp_pkg.sv
hw/rtl/mcfp_parser.sv
hw/rtl/mouse_command_frame_parser_top.sv
hw/rtl/mcfp_checker.sv
tb/mcfp_report_checker.sv
tb/mouse_command_frame_parser_top_tb.sv
